FILE: rtl/core/mlr_pkg.sv
`timescale 1ns / 1ps

package mlr_pkg;

   // Matrix geometry
   localparam int MaxDim = 32;
   localparam int IdxW   = $clog2(MaxDim);
   localparam int DimW   = $clog2(MaxDim + 1);
   localparam int AddrW  = $clog2(MaxDim * MaxDim);

   // Item field widths
   localparam int OpW    = 2;
   localparam int RowW   = 5;
   localparam int ColW   = 5;
   localparam int DataW  = 32;
   localparam int AmtW   = 8;
   localparam int StepW  = $clog2(AmtW);

   // Request tdata layout, lowest bit first: row, column, value, direction, amount
   localparam int RowLo  = 0;
   localparam int ColLo  = RowLo + RowW;
   localparam int ValLo  = ColLo + ColW;
   localparam int DirLo  = ValLo + DataW;
   localparam int AmtLo  = DirLo + 1;
   localparam int ReqBits  = AmtLo + AmtW;
   localparam int ReqDataW = ((ReqBits + 7) / 8) * 8;

   // Configuration port
   localparam int CsrIdxW = 1;
   localparam int CfgW    = 6;
   localparam logic [CsrIdxW-1:0] CSR_ROW_COUNT = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_COL_COUNT = 1'd1;

   typedef enum logic [OpW-1:0] {
      OP_WRITE   = 2'd0,
      OP_READ    = 2'd1,
      OP_ROT_ROW = 2'd2,
      OP_ROT_COL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MOD,
      ST_PREP,
      ST_GATHER,
      ST_SCATTER
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic rsp_load;
      logic mod_step;
      logic prep;
      logic gather;
      logic scatter;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type req_op;
      logic   line_ok;
      logic   rsp_free;
      logic   mod_last;
      logic   cnt_last;
   } status_type;

   // Bring a written size into the range 1 .. MaxDim
   function automatic logic [DimW-1:0] clamp_dim(input logic [CfgW-1:0] v);
      logic [DimW-1:0] r;
      if (v == '0) begin
         r = DimW'(1);
      end else if (32'(v) > MaxDim) begin
         r = DimW'(MaxDim);
      end else begin
         r = DimW'(v);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/mlr_ram.sv
`timescale 1ns / 1ps

module mlr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port, and read port with registered data held between reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/mlr_ctrl.sv
`timescale 1ns / 1ps

module mlr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mlr_pkg::status_type status,
   output mlr_pkg::cmd_type    cmd
);

   import mlr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one item at a time through the datapath
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (status.req_op)
                  OP_WRITE: state_in = ST_IDLE;
                  OP_READ:  state_in = ST_READ;
                  OP_ROT_ROW, OP_ROT_COL: begin
                     // drop a rotation of a line outside the used size
                     if (status.line_ok) begin
                        state_in = ST_MOD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            // hold the fetched word until the output register is free
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_GATHER;
         end
         ST_GATHER: begin
            cmd.gather = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_SCATTER;
            end
         end
         ST_SCATTER: begin
            cmd.scatter = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/mlr_dp.sv
`timescale 1ns / 1ps

module mlr_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  mlr_pkg::cmd_type             cmd,
   output mlr_pkg::status_type          status,
   input  logic [mlr_pkg::ReqDataW-1:0] req_tdata,
   input  logic [mlr_pkg::OpW-1:0]      req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mlr_pkg::DataW-1:0]    rsp_tdata,
   input  logic                         csr_we,
   input  logic [mlr_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [mlr_pkg::CfgW-1:0]     csr_wdata
);

   import mlr_pkg::*;

   // Request fields
   op_type            req_op;
   logic [RowW-1:0]   req_row;
   logic [ColW-1:0]   req_col;
   logic [DataW-1:0]  req_value;
   logic              req_dir;
   logic [AmtW-1:0]   req_amount;
   logic              req_elem_ok;
   logic [AddrW-1:0]  req_addr;

   assign req_op     = op_type'(req_tuser);
   assign req_row    = req_tdata[RowLo +: RowW];
   assign req_col    = req_tdata[ColLo +: ColW];
   assign req_value  = req_tdata[ValLo +: DataW];
   assign req_dir    = req_tdata[DirLo];
   assign req_amount = req_tdata[AmtLo +: AmtW];

   // Size registers
   logic [DimW-1:0] row_count_ff;
   logic [DimW-1:0] col_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DimW'(MaxDim);
         col_count_ff <= DimW'(MaxDim);
      end else if (csr_we) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_count_ff <= clamp_dim(csr_wdata);
         end
         if (csr_index == CSR_COL_COUNT) begin
            col_count_ff <= clamp_dim(csr_wdata);
         end
      end
   end

   logic req_row_ok;
   logic req_col_ok;

   assign req_row_ok  = DimW'(req_row) < row_count_ff;
   assign req_col_ok  = DimW'(req_col) < col_count_ff;
   assign req_elem_ok = req_row_ok && req_col_ok;
   assign req_addr    = AddrW'(req_row) * AddrW'(MaxDim) + AddrW'(req_col);

   // Item registers
   op_type          op_ff;
   logic [RowW-1:0] row_ff;
   logic [ColW-1:0] col_ff;
   logic            dir_ff;
   logic            elem_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff      <= req_op;
         row_ff     <= req_row;
         col_ff     <= req_col;
         dir_ff     <= req_dir;
         elem_ok_ff <= req_elem_ok;
      end
   end

   // Line length of the rotation in hand
   logic [DimW-1:0] len;

   assign len = (op_ff == OP_ROT_ROW) ? col_count_ff : row_count_ff;

   // Shift amount modulo line length, one bit of the amount a cycle
   logic [DimW-1:0]  rem_ff;
   logic [AmtW-1:0]  amt_sh_ff;
   logic [StepW-1:0] step_ff;
   logic [DimW:0]    rem_shift;
   logic [DimW:0]    rem_next;

   assign rem_shift = {rem_ff, amt_sh_ff[AmtW-1]};
   assign rem_next  = (rem_shift >= (DimW+1)'(len)) ? rem_shift - (DimW+1)'(len) : rem_shift;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rem_ff    <= '0;
         amt_sh_ff <= req_amount;
         step_ff   <= '0;
      end else if (cmd.mod_step) begin
         rem_ff    <= rem_next[DimW-1:0];
         amt_sh_ff <= {amt_sh_ff[AmtW-2:0], 1'b0};
         step_ff   <= step_ff + StepW'(1);
      end
   end

   // Line walk: source position for the gather, counter for both passes
   logic [IdxW-1:0] src_ff;
   logic [DimW-1:0] cnt_ff;
   logic [DimW-1:0] cnt_dec;
   logic [DimW-1:0] src_inc;
   logic [DimW-1:0] back_start;
   logic            cnt_last;

   assign cnt_last   = cnt_ff == len;
   assign cnt_dec    = cnt_ff - DimW'(1);
   assign src_inc    = DimW'(src_ff) + DimW'(1);
   assign back_start = (rem_ff == '0) ? '0 : len - rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         src_ff <= dir_ff ? back_start[IdxW-1:0] : rem_ff[IdxW-1:0];
         cnt_ff <= '0;
      end else if (cmd.gather || cmd.scatter) begin
         cnt_ff <= cnt_last ? '0 : cnt_ff + DimW'(1);
         if (cmd.gather && !cnt_last) begin
            src_ff <= (src_inc == len) ? '0 : src_inc[IdxW-1:0];
         end
      end
   end

   // Cell address of a position along the current line
   function automatic logic [AddrW-1:0] line_addr(input op_type op,
                                                  input logic [RowW-1:0] r,
                                                  input logic [ColW-1:0] c,
                                                  input logic [IdxW-1:0] k);
      logic [AddrW-1:0] a;
      if (op == OP_ROT_ROW) begin
         a = AddrW'(r) * AddrW'(MaxDim) + AddrW'(k);
      end else begin
         a = AddrW'(k) * AddrW'(MaxDim) + AddrW'(c);
      end
      return a;
   endfunction

   // Memory ports
   logic             cell_we;
   logic [AddrW-1:0] cell_waddr;
   logic [DataW-1:0] cell_wdata;
   logic             cell_re;
   logic [AddrW-1:0] cell_raddr;
   logic [DataW-1:0] cell_rdata;
   logic             lbuf_we;
   logic             lbuf_re;
   logic [DataW-1:0] lbuf_rdata;

   always_comb begin
      cell_we    = (cmd.accept && req_op == OP_WRITE && req_elem_ok)
                   || (cmd.scatter && cnt_ff != '0);
      cell_waddr = cmd.accept ? req_addr
                              : line_addr(op_ff, row_ff, col_ff, cnt_dec[IdxW-1:0]);
      cell_wdata = cmd.accept ? req_value : lbuf_rdata;
      cell_re    = (cmd.accept && req_op == OP_READ) || (cmd.gather && !cnt_last);
      cell_raddr = cmd.accept ? req_addr : line_addr(op_ff, row_ff, col_ff, src_ff);
      lbuf_we    = cmd.gather && cnt_ff != '0;
      lbuf_re    = cmd.scatter && !cnt_last;
   end

   mlr_ram #(
      .WIDTH (DataW),
      .DEPTH (MaxDim * MaxDim)
   ) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .re    (cell_re),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   mlr_ram #(
      .WIDTH (DataW),
      .DEPTH (MaxDim)
   ) u_line_ram (
      .clock (clock),
      .we    (lbuf_we),
      .waddr (cnt_dec[IdxW-1:0]),
      .wdata (cell_rdata),
      .re    (lbuf_re),
      .raddr (cnt_ff[IdxW-1:0]),
      .rdata (lbuf_rdata)
   );

   // Output register: load a read result, clear on transfer
   logic             rsp_valid_ff;
   logic [DataW-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= elem_ok_ff ? cell_rdata : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status
   always_comb begin
      status          = '0;
      status.req_op   = req_op;
      status.line_ok  = (req_op == OP_ROT_ROW) ? req_row_ok : req_col_ok;
      status.rsp_free = !rsp_valid_ff || rsp_tready;
      status.mod_last = step_ff == StepW'(AmtW - 1);
      status.cnt_last = cnt_last;
   end

endmodule

FILE: rtl/core/matrix_line_rotator.sv
`timescale 1ns / 1ps
// Write: the next item may be taken in the following cycle.
// Read: the word goes through the memory read register and is then loaded into the
// output register once it is free, after which the next item may be taken.
// Rotation (L = line length, at most 32): a modulo unit (one shift bit a cycle), then
// a gather pass and a scatter pass along the line through the line buffer.
// Synchronous active-high reset clears control and sets both sizes to 32; contents undefined.

module matrix_line_rotator (
   input  logic                         clock,
   input  logic                         reset,
   // tdata: row_index, col_index, element_value, direction, shift_amount, zero pad
   input  logic [mlr_pkg::ReqDataW-1:0] req_tdata,
   // tuser: operation
   input  logic [mlr_pkg::OpW-1:0]      req_tuser,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // tdata: read_value
   output logic [mlr_pkg::DataW-1:0]    rsp_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_we,
   input  logic [mlr_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [mlr_pkg::CfgW-1:0]     csr_wdata
);

   import mlr_pkg::*;

   cmd_type    cmd;
   status_type status;

   mlr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mlr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule
